/* hw/rtl/plc_pkg.sv */
// ----------------------------------------------------------------------------
// plc_pkg
// shared types and constants of the piecewise linear calibration table
// ----------------------------------------------------------------------------
package plc_pkg;

  localparam int unsigned TABLE_DEPTH_DEF = 16;

  typedef enum logic [1:0] {
    MODE_CLEAR  = 2'd0,
    MODE_INSERT = 2'd1,
    MODE_QUERY  = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_FULL    = 2'd1,
    STATUS_DUP     = 2'd2,
    STATUS_INVALID = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_INS_WR,
    S_QRY_RD,
    S_QRY_CHK,
    S_DIFF,
    S_MUL,
    S_DIV_GO,
    S_DIV_WAIT,
    S_CLAMP,
    S_SUM,
    S_DONE
  } state_t;

  typedef struct packed {
    logic        start;
    logic [63:0] num;
    logic [31:0] den;
  } plc_div_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] quo;
  } plc_div_rsp_t;

endpackage

/* hw/rtl/plc_div.sv */
// ----------------------------------------------------------------------------
// plc_div
// iterative unsigned 64 by 32 bit divider, two quotient bits per cycle
// ----------------------------------------------------------------------------
module plc_div (
  input  logic                 clk,
  input  logic                 rst_n,
  input  plc_pkg::plc_div_req_t req,
  output plc_pkg::plc_div_rsp_t rsp
);

  logic [63:0] n_r, n_nxt;
  logic [31:0] rem_r, rem_nxt;
  logic [31:0] den_r;
  logic [4:0]  cnt_r;
  logic        busy_r;
  logic        done_r;

  always_comb begin
    logic [32:0] r1;
    logic        qb;
    rem_nxt = rem_r;
    n_nxt   = n_r;
    for (int i = 0; i < 2; i++) begin
      r1 = {rem_nxt, n_nxt[63]};
      if (r1 >= {1'b0, den_r}) begin
        r1 = r1 - {1'b0, den_r};
        qb = 1'b1;
      end else begin
        qb = 1'b0;
      end
      rem_nxt = r1[31:0];
      n_nxt   = {n_nxt[62:0], qb};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == 5'd31) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      n_r   <= req.num;
      rem_r <= '0;
      den_r <= req.den;
    end else if (busy_r) begin
      n_r   <= n_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign rsp.done = done_r;
  assign rsp.quo  = n_r;

endmodule

/* hw/rtl/piecewise_linear_cal_table.sv */
// ----------------------------------------------------------------------------
// piecewise_linear_cal_table
// sorted table of signed q16.16 points, linear inter/extrapolation on query
// ----------------------------------------------------------------------------
//  channel | ports              | contents
//  in      | in_tvalid/tready   | tuser: mode; tdata: x_value, y_value
//  out     | out_tvalid/tready  | tdata: y_result, table_valid, status,
//          |                    |        saturated, point_count
//
//  clear, full table, invalid query, unused mode: straight to the done state
//  insert: a read and a check state per scanned point, then a read and a
//  write state per point shifted up, then the write of the new point
//  query: read and check per point, then diff, multiply, divide, clamp, sum
//  reset clears count, error mark and the output valid flag; points are
//  not cleared. a stalled output holds the next result in the done state
// ----------------------------------------------------------------------------
module piecewise_linear_cal_table #(
  parameter int unsigned TABLE_DEPTH = plc_pkg::TABLE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // x_value, y_value
  input  logic [1:0]  in_tuser,   // mode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata   // y_result, table_valid, status, saturated, point_count
);

  localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

  logic [63:0] mem [TABLE_DEPTH];
  logic        rd_en, wr_en;
  logic [AW-1:0] rd_addr, wr_addr;
  logic [63:0] wr_data, rd_data_r;

  plc_pkg::state_t state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          err_r, err_nxt;
  logic [AW-1:0] k_r, k_nxt, pos_r, pos_nxt, j_r, j_nxt;
  logic signed [31:0] x_r, y_r;
  logic signed [31:0] lo_x_r, lo_x_nxt, lo_y_r, lo_y_nxt, hi_x_r, hi_x_nxt, hi_y_r, hi_y_nxt;
  logic [31:0] mx_r, my_r, d_r;
  logic        neg_r;
  logic [63:0] prod_r;
  logic signed [41:0] qs_r;
  logic signed [31:0] yres_r, yres_nxt;
  plc_pkg::status_t status_r, status_nxt;
  logic        sat_r, sat_nxt;
  logic        out_valid_r;
  logic [47:0] out_data_r;
  logic        load_out;

  plc_pkg::plc_div_req_t div_req;
  plc_pkg::plc_div_rsp_t div_rsp;

  logic signed [31:0] rd_x, rd_y;
  logic [AW-1:0]      last_idx;
  logic               tbl_ok;
  logic signed [32:0] dx, dy, dd;
  logic [40:0]        qmag;
  logic signed [41:0] sum;

  assign rd_x     = rd_data_r[31:0];
  assign rd_y     = rd_data_r[63:32];
  assign last_idx = AW'(cnt_r - CW'(1));
  assign tbl_ok   = !err_r && (cnt_r >= CW'(2));
  assign in_tready = (state_r == plc_pkg::S_IDLE);

  assign dx = {x_r[31], x_r} - {lo_x_r[31], lo_x_r};
  assign dy = {hi_y_r[31], hi_y_r} - {lo_y_r[31], lo_y_r};
  assign dd = {hi_x_r[31], hi_x_r} - {lo_x_r[31], lo_x_r};
  assign qmag = (div_rsp.quo > (64'd1 << 40)) ? (41'd1 << 40) : div_rsp.quo[40:0];
  assign sum = 42'(lo_y_r) + qs_r;

  assign div_req.start = (state_r == plc_pkg::S_DIV_GO);
  assign div_req.num   = prod_r;
  assign div_req.den   = d_r;

  plc_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (div_req),
    .rsp  (div_rsp)
  );

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    err_nxt    = err_r;
    k_nxt      = k_r;
    pos_nxt    = pos_r;
    j_nxt      = j_r;
    lo_x_nxt   = lo_x_r;
    lo_y_nxt   = lo_y_r;
    hi_x_nxt   = hi_x_r;
    hi_y_nxt   = hi_y_r;
    yres_nxt   = yres_r;
    status_nxt = status_r;
    sat_nxt    = sat_r;
    rd_en      = 1'b0;
    rd_addr    = k_r;
    wr_en      = 1'b0;
    wr_addr    = j_r;
    wr_data    = rd_data_r;
    load_out   = 1'b0;
    unique case (state_r)
      plc_pkg::S_IDLE: begin
        if (in_tvalid) begin
          yres_nxt   = '0;
          status_nxt = plc_pkg::STATUS_OK;
          sat_nxt    = 1'b0;
          k_nxt      = '0;
          state_nxt  = plc_pkg::S_DONE;
          unique case (in_tuser)
            plc_pkg::MODE_CLEAR: begin
              cnt_nxt = '0;
              err_nxt = 1'b0;
            end
            plc_pkg::MODE_INSERT: begin
              if (cnt_r == CW'(TABLE_DEPTH)) begin
                status_nxt = plc_pkg::STATUS_FULL;
                err_nxt    = 1'b1;
              end else if (cnt_r == '0) begin
                pos_nxt   = '0;
                state_nxt = plc_pkg::S_INS_WR;
              end else begin
                state_nxt = plc_pkg::S_SCAN_RD;
              end
            end
            plc_pkg::MODE_QUERY: begin
              if (!tbl_ok) begin
                status_nxt = plc_pkg::STATUS_INVALID;
              end else begin
                state_nxt = plc_pkg::S_QRY_RD;
              end
            end
            default: begin
              state_nxt = plc_pkg::S_DONE;
            end
          endcase
        end
      end
      plc_pkg::S_SCAN_RD: begin
        rd_en     = 1'b1;
        state_nxt = plc_pkg::S_SCAN_CHK;
      end
      plc_pkg::S_SCAN_CHK: begin
        if (rd_x == x_r) begin
          status_nxt = plc_pkg::STATUS_DUP;
          err_nxt    = 1'b1;
          state_nxt  = plc_pkg::S_DONE;
        end else if (rd_x > x_r) begin
          pos_nxt   = k_r;
          j_nxt     = AW'(cnt_r);
          state_nxt = plc_pkg::S_SHIFT_RD;
        end else if (CW'(k_r) + CW'(1) == cnt_r) begin
          pos_nxt   = AW'(cnt_r);
          state_nxt = plc_pkg::S_INS_WR;
        end else begin
          k_nxt     = k_r + AW'(1);
          state_nxt = plc_pkg::S_SCAN_RD;
        end
      end
      plc_pkg::S_SHIFT_RD: begin
        if (j_r == pos_r) begin
          state_nxt = plc_pkg::S_INS_WR;
        end else begin
          rd_en     = 1'b1;
          rd_addr   = j_r - AW'(1);
          state_nxt = plc_pkg::S_SHIFT_WR;
        end
      end
      plc_pkg::S_SHIFT_WR: begin
        wr_en     = 1'b1;
        wr_addr   = j_r;
        j_nxt     = j_r - AW'(1);
        state_nxt = plc_pkg::S_SHIFT_RD;
      end
      plc_pkg::S_INS_WR: begin
        wr_en     = 1'b1;
        wr_addr   = pos_r;
        wr_data   = {y_r, x_r};
        cnt_nxt   = cnt_r + CW'(1);
        state_nxt = plc_pkg::S_DONE;
      end
      plc_pkg::S_QRY_RD: begin
        rd_en     = 1'b1;
        state_nxt = plc_pkg::S_QRY_CHK;
      end
      plc_pkg::S_QRY_CHK: begin
        if (k_r == '0) begin
          lo_x_nxt  = rd_x;
          lo_y_nxt  = rd_y;
          k_nxt     = AW'(1);
          state_nxt = plc_pkg::S_QRY_RD;
        end else if (rd_x >= x_r || k_r == last_idx) begin
          hi_x_nxt  = rd_x;
          hi_y_nxt  = rd_y;
          state_nxt = plc_pkg::S_DIFF;
        end else begin
          lo_x_nxt  = rd_x;
          lo_y_nxt  = rd_y;
          k_nxt     = k_r + AW'(1);
          state_nxt = plc_pkg::S_QRY_RD;
        end
      end
      plc_pkg::S_DIFF: begin
        state_nxt = plc_pkg::S_MUL;
      end
      plc_pkg::S_MUL: begin
        state_nxt = plc_pkg::S_DIV_GO;
      end
      plc_pkg::S_DIV_GO: begin
        state_nxt = plc_pkg::S_DIV_WAIT;
      end
      plc_pkg::S_DIV_WAIT: begin
        if (div_rsp.done) begin
          state_nxt = plc_pkg::S_CLAMP;
        end
      end
      plc_pkg::S_CLAMP: begin
        state_nxt = plc_pkg::S_SUM;
      end
      plc_pkg::S_SUM: begin
        if (sum > 42'sd2147483647) begin
          yres_nxt = 32'sh7fffffff;
          sat_nxt  = 1'b1;
        end else if (sum < -42'sd2147483648) begin
          yres_nxt = 32'sh80000000;
          sat_nxt  = 1'b1;
        end else begin
          yres_nxt = sum[31:0];
        end
        state_nxt = plc_pkg::S_DONE;
      end
      plc_pkg::S_DONE: begin
        if (!out_valid_r || out_tready) begin
          load_out  = 1'b1;
          state_nxt = plc_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = plc_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= plc_pkg::S_IDLE;
      cnt_r       <= '0;
      err_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      err_r   <= err_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    k_r      <= k_nxt;
    pos_r    <= pos_nxt;
    j_r      <= j_nxt;
    lo_x_r   <= lo_x_nxt;
    lo_y_r   <= lo_y_nxt;
    hi_x_r   <= hi_x_nxt;
    hi_y_r   <= hi_y_nxt;
    yres_r   <= yres_nxt;
    status_r <= status_nxt;
    sat_r    <= sat_nxt;
    if (in_tvalid && in_tready) begin
      x_r <= in_tdata[31:0];
      y_r <= in_tdata[63:32];
    end
    if (state_r == plc_pkg::S_DIFF) begin
      mx_r  <= dx[32] ? 32'(-dx) : dx[31:0];
      my_r  <= dy[32] ? 32'(-dy) : dy[31:0];
      neg_r <= dx[32] ^ dy[32];
      d_r   <= dd[31:0];
    end
    if (state_r == plc_pkg::S_MUL) begin
      prod_r <= mx_r * my_r;
    end
    if (state_r == plc_pkg::S_CLAMP) begin
      qs_r <= neg_r ? -$signed({1'b0, qmag}) : $signed({1'b0, qmag});
    end
    if (load_out) begin
      out_data_r <= {7'd0, 5'(cnt_r), sat_r, status_r, tbl_ok, yres_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

/* hw/rtl/plc_checker.sv */
// ----------------------------------------------------------------------------
// plc_checker
// port level checks of the calibration table, bound to the top level
// ----------------------------------------------------------------------------
module plc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [47:0] out_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("output beat changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken while a beat is in work");

  a_invalid_query: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[34:33] == plc_pkg::STATUS_INVALID
      |-> out_tdata[31:0] == 32'd0 && !out_tdata[32])
    else $error("invalid table query with nonzero result");

  a_sat_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[35] |-> out_tdata[34:33] == plc_pkg::STATUS_OK && out_tdata[32])
    else $error("saturation flag outside a valid query");

endmodule

bind piecewise_linear_cal_table plc_checker u_plc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_tvalid (in_tvalid),
  .in_tready (in_tready),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata)
);
